// File: rtl/core/rhpm_pkg.sv
// Shared widths, constants and command codes for the rolling hash pattern matcher.
package rhpm_pkg;

    localparam int BYTE_W          = 8;
    localparam int HASH_W          = 13;
    localparam int POS_W           = 24;
    localparam int RED_W           = HASH_W + BYTE_W;
    localparam int MAX_PATTERN_DEF = 64;

    localparam logic [POS_W-1:0]  POS_MAX   = {POS_W{1'b1}};
    localparam logic [HASH_W-1:0] MOD_RESET = HASH_W'(101);

    localparam logic CMD_PATTERN = 1'b0;
    localparam logic CMD_TEXT    = 1'b1;

endpackage

// File: rtl/core/rhpm_modred.sv
// Bit-serial restoring reduction of a RED_W-bit operand modulo a 13-bit modulus.
module rhpm_modred
    import rhpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RED_W-1:0]  operand,
    input  logic [HASH_W-1:0] modulus,
    output logic              done,
    output logic [HASH_W-1:0] result
);

    localparam int CNT_W = $clog2(RED_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [RED_W-1:0]  sh_reg;
    logic [HASH_W-1:0] rem_reg;
    logic [HASH_W:0]   trial;
    logic [HASH_W:0]   diff;

    // shift in one operand bit, subtract the modulus once if it fits
    assign trial = {rem_reg, sh_reg[RED_W-1]};
    assign diff  = trial - {1'b0, modulus};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(RED_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= operand;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            sh_reg <= {sh_reg[RED_W-2:0], 1'b0};
            if (trial >= {1'b0, modulus})
                rem_reg <= diff[HASH_W-1:0];
            else
                rem_reg <= trial[HASH_W-1:0];
        end
    end

    assign done   = done_reg;
    assign result = rem_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("reduction done without a run");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("reduction restarted while busy");

    a_rem_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && $past(busy_reg)) |-> (rem_reg < modulus))
        else $error("partial remainder not below modulus");

endmodule

// File: rtl/core/rolling_hash_pattern_matcher.sv
// Top level of the Rabin-Karp rolling hash pattern matcher.
//
// Input channel (in_valid/in_ready): one beat is a byte. cmd 0 loads a pattern
// byte, cmd 1 streams a text byte; is_last closes the pattern or the text.
// Pattern bytes give no result. Each text byte gives exactly one result beat on
// the output channel (out_valid/out_ready): match flag, start index, done flag
// and the sticky any-match flag of this text.
// All modular reductions run through one bit-serial reducer that takes one
// operand bit per cycle, with a start and a wait state around each reduction.
//   text byte, window filling : one reduction (shift-in)
//   text byte, window full    : old-byte product, subtract, shift-in,
//                               plus up to one read and compare per
//                               pattern byte on a hash hit
//   last pattern byte         : builds the pattern hash and the radix
//                               power, one reduction per step
// The block takes one beat at a time and is ready only while idle. The result
// sits in an output register, so a new beat is accepted while the previous
// result still waits; a stalled receiver only holds the block at its final
// step. Reset clears all control state, sets the modulus to 101 and the
// radix power to 1; no clearing pass is needed. The modulus written through
// cfg_wr_data is taken up when a pattern completes.
module rolling_hash_pattern_matcher
    import rhpm_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration
    input  logic              cfg_wr_en,
    input  logic [HASH_W-1:0] cfg_wr_data,
    // input channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              cmd,
    input  logic [BYTE_W-1:0] byte_value,
    input  logic              is_last,
    // output channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic              match_found,
    output logic [POS_W-1:0]  match_start,
    output logic              text_done,
    output logic              any_match
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int PW    = LEN_W + 1;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_T_MUL = 4'd1;   // old byte times radix power
    localparam logic [3:0] S_T_SGO = 4'd2;   // reduce the product
    localparam logic [3:0] S_T_SW  = 4'd3;
    localparam logic [3:0] S_T_NGO = 4'd4;   // reduce hash*256 + byte
    localparam logic [3:0] S_T_NW  = 4'd5;
    localparam logic [3:0] S_T_WR  = 4'd6;   // ring write, hit check
    localparam logic [3:0] S_C_SET = 4'd7;
    localparam logic [3:0] S_C_RD  = 4'd8;
    localparam logic [3:0] S_C_CHK = 4'd9;
    localparam logic [3:0] S_T_OUT = 4'd10;
    localparam logic [3:0] S_P_RD  = 4'd11;
    localparam logic [3:0] S_P_HGO = 4'd12;  // pattern hash step
    localparam logic [3:0] S_P_HW  = 4'd13;
    localparam logic [3:0] S_P_RGO = 4'd14;  // radix power step
    localparam logic [3:0] S_P_RW  = 4'd15;

    logic [3:0]        state_reg, state_next;
    logic [HASH_W-1:0] hmod_reg;
    logic [HASH_W-1:0] aq_reg, aq_next;
    logic [LEN_W-1:0]  plen_reg, plen_next;
    logic [HASH_W-1:0] ph_reg, ph_next;
    logic [HASH_W-1:0] rp_reg, rp_next;
    logic [HASH_W-1:0] wh_reg, wh_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              found_reg, found_next;
    logic [LEN_W-1:0]  lc_reg, lc_next;
    logic              loading_reg, loading_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [IDX_W-1:0]  head_reg, head_next;
    logic [IDX_W-1:0]  cpos_reg, cpos_next;
    logic [LEN_W-1:0]  j_reg, j_next;
    logic              hit_reg, hit_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              last_reg, last_next;
    logic [RED_W-1:0]  prod_reg, prod_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_load;

    logic              out_found_reg;
    logic [POS_W-1:0]  out_start_reg;
    logic              out_done_reg;
    logic              out_any_reg;
    logic [POS_W-1:0]  start_calc;

    // pattern store and window ring, one write and one registered read each
    logic [BYTE_W-1:0] pat_mem  [MAX_PATTERN];
    logic [BYTE_W-1:0] ring_mem [MAX_PATTERN];
    logic [BYTE_W-1:0] pat_rdata_reg;
    logic [BYTE_W-1:0] ring_rdata_reg;
    logic              pat_we;
    logic [IDX_W-1:0]  pat_waddr;
    logic              ring_we;
    logic [IDX_W-1:0]  ring_raddr;

    logic              in_fire;
    logic [LEN_W-1:0]  lc_eff;
    logic [LEN_W-1:0]  lc_new;
    logic [LEN_W-1:0]  fill_new;
    logic [PW-1:0]     head_x;
    logic [PW-1:0]     plen_x;
    logic [PW-1:0]     back_x;
    logic [IDX_W-1:0]  ring_back;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  cpos_inc;
    logic [HASH_W:0]   sub_t;
    logic [HASH_W:0]   sub_d;

    logic              red_start;
    logic [RED_W-1:0]  red_operand;
    logic              red_done;
    logic [HASH_W-1:0] red_result;

    rhpm_modred u_modred (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (red_start),
        .operand (red_operand),
        .modulus (aq_reg),
        .done    (red_done),
        .result  (red_result)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_load  = (state_reg == S_T_OUT) && (!out_valid_reg || out_ready);

    // ring slot M bytes behind the head: oldest byte before the write,
    // window start after it
    assign head_x    = PW'(head_reg);
    assign plen_x    = PW'(plen_reg);
    assign back_x    = (head_x >= plen_x) ? (head_x - plen_x)
                                          : (head_x + PW'(MAX_PATTERN) - plen_x);
    assign ring_back = back_x[IDX_W-1:0];
    assign head_inc  = (head_reg == IDX_W'(MAX_PATTERN - 1)) ? '0 : head_reg + IDX_W'(1);
    assign cpos_inc  = (cpos_reg == IDX_W'(MAX_PATTERN - 1)) ? '0 : cpos_reg + IDX_W'(1);
    assign ring_raddr = (state_reg == S_C_RD) ? cpos_reg : ring_back;

    assign lc_eff   = loading_reg ? lc_reg : '0;
    assign pat_we   = in_fire && (cmd == CMD_PATTERN) && (lc_eff < LEN_W'(MAX_PATTERN));
    assign pat_waddr = lc_eff[IDX_W-1:0];
    assign lc_new   = pat_we ? lc_eff + LEN_W'(1) : lc_eff;
    assign fill_new = (fill_reg < plen_reg) ? fill_reg + LEN_W'(1) : fill_reg;
    assign ring_we  = (state_reg == S_T_WR);

    // (hash + q - sub) mod q, both terms already below q
    assign sub_t = {1'b0, wh_reg} + {1'b0, aq_reg} - {1'b0, red_result};
    assign sub_d = sub_t - {1'b0, aq_reg};

    assign start_calc = (pos_reg >= POS_MAX) ? POS_MAX
                      : pos_reg - (POS_W'(plen_reg) - POS_W'(1));

    always_comb
    begin
        red_start = (state_reg == S_T_SGO) || (state_reg == S_T_NGO) ||
                    (state_reg == S_P_HGO) || (state_reg == S_P_RGO);
        case (state_reg)
            S_T_SGO: red_operand = prod_reg;
            S_T_NGO: red_operand = {wh_reg, byte_reg};
            S_P_HGO: red_operand = {ph_reg, pat_rdata_reg};
            S_P_RGO: red_operand = {rp_reg, {BYTE_W{1'b0}}};
            default: red_operand = prod_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        aq_next        = aq_reg;
        plen_next      = plen_reg;
        ph_next        = ph_reg;
        rp_next        = rp_reg;
        wh_next        = wh_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        lc_next        = lc_reg;
        loading_next   = loading_reg;
        fill_next      = fill_reg;
        head_next      = head_reg;
        cpos_next      = cpos_reg;
        j_next         = j_reg;
        hit_next       = hit_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    byte_next = byte_value;
                    last_next = is_last;
                    hit_next  = 1'b0;
                    if (cmd == CMD_PATTERN)
                    begin
                        if (!loading_reg)
                        begin
                            // new pattern drops the text state
                            plen_next  = '0;
                            wh_next    = '0;
                            pos_next   = '0;
                            found_next = 1'b0;
                            fill_next  = '0;
                            head_next  = '0;
                        end
                        lc_next      = lc_new;
                        loading_next = 1'b1;
                        if (is_last)
                        begin
                            loading_next = 1'b0;
                            aq_next      = (hmod_reg < HASH_W'(2)) ? HASH_W'(1) : hmod_reg;
                            rp_next      = (hmod_reg < HASH_W'(2)) ? '0 : HASH_W'(1);
                            plen_next    = lc_new;
                            ph_next      = '0;
                            j_next       = '0;
                            state_next   = S_P_RD;
                        end
                    end
                    else if (plen_reg == '0)
                        state_next = S_T_OUT;
                    else if (fill_reg < plen_reg)
                        state_next = S_T_NGO;
                    else
                        state_next = S_T_MUL;
                end
            end

            S_T_MUL:
            begin
                prod_next  = {{HASH_W{1'b0}}, ring_rdata_reg} * {{BYTE_W{1'b0}}, rp_reg};
                state_next = S_T_SGO;
            end

            S_T_SGO: state_next = S_T_SW;

            S_T_SW:
            begin
                if (red_done)
                begin
                    wh_next    = (sub_t >= {1'b0, aq_reg}) ? sub_d[HASH_W-1:0]
                                                           : sub_t[HASH_W-1:0];
                    state_next = S_T_NGO;
                end
            end

            S_T_NGO: state_next = S_T_NW;

            S_T_NW:
            begin
                if (red_done)
                begin
                    wh_next    = red_result;
                    state_next = S_T_WR;
                end
            end

            S_T_WR:
            begin
                head_next = head_inc;
                fill_next = fill_new;
                if ((fill_new == plen_reg) && (wh_reg == ph_reg))
                begin
                    j_next     = '0;
                    state_next = S_C_SET;
                end
                else
                    state_next = S_T_OUT;
            end

            S_C_SET:
            begin
                cpos_next  = ring_back;
                state_next = S_C_RD;
            end

            S_C_RD: state_next = S_C_CHK;

            S_C_CHK:
            begin
                if (ring_rdata_reg != pat_rdata_reg)
                    state_next = S_T_OUT;
                else if (j_reg == plen_reg - LEN_W'(1))
                begin
                    hit_next   = 1'b1;
                    state_next = S_T_OUT;
                end
                else
                begin
                    j_next     = j_reg + LEN_W'(1);
                    cpos_next  = cpos_inc;
                    state_next = S_C_RD;
                end
            end

            S_T_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    found_next     = found_reg || hit_reg;
                    if (pos_reg < POS_MAX)
                        pos_next = pos_reg + POS_W'(1);
                    if (last_reg)
                    begin
                        wh_next    = '0;
                        pos_next   = '0;
                        found_next = 1'b0;
                        fill_next  = '0;
                        head_next  = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            S_P_RD: state_next = S_P_HGO;

            S_P_HGO: state_next = S_P_HW;

            S_P_HW:
            begin
                if (red_done)
                begin
                    ph_next = red_result;
                    if (j_reg == plen_reg - LEN_W'(1))
                    begin
                        if (plen_reg > LEN_W'(1))
                        begin
                            j_next     = LEN_W'(1);
                            state_next = S_P_RGO;
                        end
                        else
                            state_next = S_IDLE;
                    end
                    else
                    begin
                        j_next     = j_reg + LEN_W'(1);
                        state_next = S_P_RD;
                    end
                end
            end

            S_P_RGO: state_next = S_P_RW;

            S_P_RW:
            begin
                if (red_done)
                begin
                    rp_next = red_result;
                    if (j_reg == plen_reg - LEN_W'(1))
                        state_next = S_IDLE;
                    else
                    begin
                        j_next     = j_reg + LEN_W'(1);
                        state_next = S_P_RGO;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hmod_reg      <= MOD_RESET;
            aq_reg        <= MOD_RESET;
            plen_reg      <= '0;
            ph_reg        <= '0;
            rp_reg        <= HASH_W'(1);
            wh_reg        <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            lc_reg        <= '0;
            loading_reg   <= 1'b0;
            fill_reg      <= '0;
            head_reg      <= '0;
            cpos_reg      <= '0;
            j_reg         <= '0;
            hit_reg       <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
                hmod_reg <= cfg_wr_data;
            aq_reg        <= aq_next;
            plen_reg      <= plen_next;
            ph_reg        <= ph_next;
            rp_reg        <= rp_next;
            wh_reg        <= wh_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            lc_reg        <= lc_next;
            loading_reg   <= loading_next;
            fill_reg      <= fill_next;
            head_reg      <= head_next;
            cpos_reg      <= cpos_next;
            j_reg         <= j_next;
            hit_reg       <= hit_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath and result payload
    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        prod_reg <= prod_next;
        if (out_load)
        begin
            out_found_reg <= hit_reg;
            out_start_reg <= hit_reg ? start_calc : '0;
            out_done_reg  <= last_reg;
            out_any_reg   <= found_reg || hit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pat_we)
            pat_mem[pat_waddr] <= byte_value;
        pat_rdata_reg <= pat_mem[j_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[head_reg] <= byte_reg;
        ring_rdata_reg <= ring_mem[ring_raddr];
    end

    assign match_found = out_found_reg;
    assign match_start = out_start_reg;
    assign text_done   = out_done_reg;
    assign any_match   = out_any_reg;

    a_fill_le_len: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= plen_reg)
        else $error("window fill beyond pattern length");

    a_hash_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (wh_reg < aq_reg) && (ph_reg < aq_reg) && (rp_reg < aq_reg))
        else $error("hash state not reduced modulo q");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        red_done |-> ((state_reg == S_T_SW) || (state_reg == S_T_NW) ||
                      (state_reg == S_P_HW) || (state_reg == S_P_RW)))
        else $error("reduction result arrived outside a wait state");

    a_hit_after_compare: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hit_reg) |-> ($past(state_reg) == S_C_CHK))
        else $error("match flagged without a byte compare");

endmodule
